// ----- src/rsth_pkg.sv -----
// Shared types and codes for the return stack and target history block.
// No dependencies.
package rsth_pkg;

  localparam int unsigned AddrW = 64;
  localparam int unsigned CallOffset = 4;

  typedef enum logic [1:0] {
    KIND_OTHER         = 2'd0,
    KIND_DIRECT_CALL   = 2'd1,
    KIND_INDIRECT_CALL = 2'd2,
    KIND_RETURN        = 2'd3
  } kind_e;

  typedef struct packed {
    logic [AddrW-1:0] branch_address;
    kind_e            branch_kind;
    logic [AddrW-1:0] target_address;
  } branch_t;

endpackage

// ----- src/rsth_history.sv -----
// Target-path history shift register, updated once per branch beat.
// Depends on rsth_pkg.
module rsth_history #(
  parameter int unsigned HISTORY_WORDS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [rsth_pkg::AddrW-1:0] target_i,
  output logic [rsth_pkg::AddrW-1:0] word0_d_o
);
  import rsth_pkg::*;

  logic [AddrW-1:0] hist_q [HISTORY_WORDS];
  logic [AddrW-1:0] hist_d [HISTORY_WORDS];

  // carry into word w is bits 33:32 of word w-1 after its update
  always_comb begin
    hist_d[0] = (hist_q[0] << 2) ^ {{(AddrW-8){1'b0}}, target_i[9:2]};
    for (int w = 1; w < HISTORY_WORDS; w++) begin
      hist_d[w] = (hist_q[w] << 2) ^ {{(AddrW-2){1'b0}}, hist_d[w-1][33:32]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < HISTORY_WORDS; w++) begin
        hist_q[w] <= '0;
      end
    end else if (en_i) begin
      for (int w = 0; w < HISTORY_WORDS; w++) begin
        hist_q[w] <= hist_d[w];
      end
    end
  end

  assign word0_d_o = hist_d[0];

endmodule

// ----- src/rsth_stack.sv -----
// Circular return address stack with saturating live count and cached top entry.
// Depends on rsth_pkg.
module rsth_stack #(
  parameter int unsigned STACK_DEPTH = 16,
  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  rsth_pkg::branch_t         branch_i,
  output logic [rsth_pkg::AddrW-1:0] top_d_o,
  output logic [CntW-1:0]           cnt_d_o
);
  import rsth_pkg::*;

  localparam int unsigned PtrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(STACK_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(STACK_DEPTH);

  logic [AddrW-1:0] stack_q [STACK_DEPTH];
  logic [AddrW-1:0] top_q, top_d, push_val;
  logic [PtrW-1:0]  ptr_q, ptr_d, ptr_up, ptr_dn;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             is_call, is_pop;

  assign ptr_up   = (ptr_q == PtrLast) ? '0 : ptr_q + PtrW'(1);
  assign ptr_dn   = (ptr_q == '0) ? PtrLast : ptr_q - PtrW'(1);
  assign push_val = branch_i.branch_address + AddrW'(CallOffset);

  assign is_call = (branch_i.branch_kind == KIND_DIRECT_CALL) ||
                   (branch_i.branch_kind == KIND_INDIRECT_CALL);
  // other branches that hit a live top also pop
  assign is_pop  = (branch_i.branch_kind == KIND_RETURN) ||
                   ((branch_i.branch_kind == KIND_OTHER) && (cnt_q != '0) &&
                    (top_q == branch_i.target_address));

  always_comb begin
    ptr_d = ptr_q;
    cnt_d = cnt_q;
    top_d = top_q;
    if (is_call) begin
      ptr_d = ptr_up;
      cnt_d = (cnt_q == CntFull) ? cnt_q : cnt_q + CntW'(1);
      top_d = push_val;
    end else if (is_pop) begin
      ptr_d = ptr_dn;
      cnt_d = (cnt_q != '0) ? cnt_q - CntW'(1) : cnt_q;
      top_d = stack_q[ptr_dn];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      cnt_q <= '0;
      top_q <= '0;
      for (int i = 0; i < STACK_DEPTH; i++) begin
        stack_q[i] <= '0;
      end
    end else if (en_i) begin
      ptr_q <= ptr_d;
      cnt_q <= cnt_d;
      top_q <= top_d;
      if (is_call) begin
        stack_q[ptr_up] <= push_val;
      end
    end
  end

  assign top_d_o = top_d;
  assign cnt_d_o = cnt_d;

endmodule

// ----- src/return_stack_and_target_history.sv -----
// Top level: input beat register, stack and history update, result register.
// Depends on rsth_pkg, rsth_history and rsth_stack.
//
// Usage:
//   Input channel (branch_*_i, target_address_i) carries one resolved branch
//   per beat. Output channel carries the updated return prediction, its valid
//   flag, the live stack count and the lowest history word.
//   Each input beat gives exactly one output beat, in order.
//   An accepted beat passes the input register, then the result register, which
//   raises out_valid_o; a stalled output keeps it waiting in the input register.
//   Throughput: one beat per cycle while the output is not stalled; the stack
//   pointer, count and history all update between the registers as a beat advances.
//   Reset: history, stack entries, pointer and count clear to zero, and both
//   pipeline registers empty.
//   Output stall: the result register holds; the input register still takes
//   one more beat, after which in_ready_o drops until out_ready_i returns.
module return_stack_and_target_history #(
  parameter int unsigned STACK_DEPTH   = 16,
  parameter int unsigned HISTORY_WORDS = 16,
  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [rsth_pkg::AddrW-1:0] branch_address_i,
  input  logic [1:0]                 branch_kind_i,
  input  logic [rsth_pkg::AddrW-1:0] target_address_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [rsth_pkg::AddrW-1:0] return_prediction_o,
  output logic                       return_valid_o,
  output logic [CntW-1:0]            stack_count_o,
  output logic [rsth_pkg::AddrW-1:0] history_low_word_o
);
  import rsth_pkg::*;

  branch_t          in_q;
  logic             in_valid_q;
  logic             out_valid_q;
  logic             advance;
  logic             in_fire;
  logic [AddrW-1:0] top_d, hist0_d;
  logic [CntW-1:0]  cnt_d;
  logic [AddrW-1:0] pred_q, hist_q;
  logic [CntW-1:0]  cnt_q;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q.branch_address <= branch_address_i;
      in_q.branch_kind    <= kind_e'(branch_kind_i);
      in_q.target_address <= target_address_i;
    end
  end

  rsth_history #(
    .HISTORY_WORDS(HISTORY_WORDS)
  ) u_history (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .target_i (in_q.target_address),
    .word0_d_o(hist0_d)
  );

  rsth_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .branch_i(in_q),
    .top_d_o (top_d),
    .cnt_d_o (cnt_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pred_q <= top_d;
      cnt_q  <= cnt_d;
      hist_q <= hist0_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign return_prediction_o = pred_q;
  assign return_valid_o      = (cnt_q != '0);
  assign stack_count_o       = cnt_q;
  assign history_low_word_o  = hist_q;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Testbench for return_stack_and_target_history: a directed table of branch beats, then random
// call/return sequences; each beat checked against its typed row or a stack and history model.
// Depends on rsth_pkg and the return_stack_and_target_history RTL.
module tb;
  import rsth_pkg::*;

  localparam int unsigned Depth = 16;
  localparam int unsigned HistWords = 16;
  localparam int unsigned RandBeats = 1600;
  localparam int unsigned StallPct = 6;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned MaxShown = 10;
  localparam logic [63:0] RowStep = 64'h100;

  typedef struct packed {
    logic [63:0] prediction;
    logic        valid;
    logic [4:0]  count;
    logic [63:0] history;
  } ras_result_t;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] addr;
    logic [63:0] target;
    logic [7:0]  reps;
    logic        typed;
    ras_result_t want;
  } branch_row_t;

  localparam int NumRows = 11;

  // Typed rows follow from reset state; the rest go through the predictor.
  branch_row_t dir_rows [NumRows] = '{
    '{KIND_OTHER, 64'h0, 64'h0, 8'd1, 1'b1, '{64'h0, 1'b0, 5'd0, 64'h0}},
    // return on empty stack: pointer still moves down
    '{KIND_RETURN, 64'h0, 64'h0, 8'd1, 1'b1, '{64'h0, 1'b0, 5'd0, 64'h0}},
    // call from the top address: address+4 wraps
    '{KIND_DIRECT_CALL, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 8'd1, 1'b1,
      '{64'h3, 1'b1, 5'd1, 64'h0}},
    // other branch hitting the top entry pops it
    '{KIND_OTHER, 64'h10, 64'h3, 8'd1, 1'b1, '{64'h0, 1'b0, 5'd0, 64'h0}},
    '{KIND_OTHER, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'd1, 1'b1,
      '{64'h0, 1'b0, 5'd0, 64'hFF}},
    '{KIND_RETURN, 64'h20, 64'h0, 8'd1, 1'b1, '{64'h0, 1'b0, 5'd0, 64'h3FC}},
    // fill the stack, then push past full
    '{KIND_DIRECT_CALL, 64'h8000_0000_0000_0000, 64'h3FC, 8'd8, 1'b0, '0},
    '{KIND_INDIRECT_CALL, 64'h4000_0000_0000_1000, 64'hAAAA_AAAA_AAAA_AAAA, 8'd9, 1'b0, '0},
    '{KIND_OTHER, 64'h123, 64'h4000_0000_0000_1804, 8'd1, 1'b0, '0},
    '{KIND_OTHER, 64'h456, 64'h5555_5555_5555_5555, 8'd1, 1'b0, '0},
    '{KIND_RETURN, 64'h789, 64'h0, 8'd2, 1'b0, '0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [63:0] branch_address_i = '0;
  logic [1:0]  branch_kind_i = '0;
  logic [63:0] target_address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] return_prediction_o;
  logic        return_valid_o;
  logic [4:0]  stack_count_o;
  logic [63:0] history_low_word_o;

  logic [63:0] path_hist [HistWords];
  logic [63:0] ret_stack [Depth];
  logic [3:0]  tos_ptr;
  logic [4:0]  live_cnt;
  ras_result_t pending_results [$];
  int unsigned bad_count = 0;
  int unsigned idle_cycles = 0;
  bit          calm = 1'b0;

  return_stack_and_target_history #(
    .STACK_DEPTH  (Depth),
    .HISTORY_WORDS(HistWords)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .branch_address_i   (branch_address_i),
    .branch_kind_i      (branch_kind_i),
    .target_address_i   (target_address_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .return_prediction_o(return_prediction_o),
    .return_valid_o     (return_valid_o),
    .stack_count_o      (stack_count_o),
    .history_low_word_o (history_low_word_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic ras_result_t resolve_branch(logic [63:0] addr, kind_e kind,
                                                 logic [63:0] tgt);
    logic [63:0] carry;
    ras_result_t res;
    carry = {56'd0, tgt[9:2]};
    for (int w = 0; w < HistWords; w++) begin
      path_hist[w] = (path_hist[w] << 2) ^ carry;
      carry = {62'd0, path_hist[w][33:32]};
    end
    if (kind == KIND_DIRECT_CALL || kind == KIND_INDIRECT_CALL) begin
      if (live_cnt < Depth) live_cnt = live_cnt + 5'd1;
      tos_ptr = tos_ptr + 4'd1;
      ret_stack[tos_ptr] = addr + 64'(CallOffset);
    end else if (kind == KIND_RETURN ||
                 (live_cnt != 0 && ret_stack[tos_ptr] == tgt)) begin
      if (live_cnt != 0) live_cnt = live_cnt - 5'd1;
      tos_ptr = tos_ptr - 4'd1;
    end
    res.prediction = ret_stack[tos_ptr];
    res.valid = (live_cnt != 0);
    res.count = live_cnt;
    res.history = path_hist[0];
    return res;
  endfunction

  task automatic send_branch(input logic [63:0] addr, input kind_e kind, input logic [63:0] tgt,
                             input logic typed, input ras_result_t want);
    ras_result_t predicted;
    while (!calm && $urandom_range(99) < StallPct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    branch_address_i <= addr;
    branch_kind_i <= kind;
    target_address_i <= tgt;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = resolve_branch(addr, kind, tgt);
    pending_results.push_back(typed ? want : predicted);
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      bad_count++;
      if (bad_count <= MaxShown) begin
        $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    ras_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        bad_count++;
        if (bad_count <= MaxShown) $display("%0t: output beat with nothing pending", $time);
      end else begin
        want = pending_results.pop_front();
        check_field("return_prediction", want.prediction, return_prediction_o);
        check_field("return_valid", 64'(want.valid), 64'(return_valid_o));
        check_field("stack_count", 64'(want.count), 64'(stack_count_o));
        check_field("history_low_word", want.history, history_low_word_o);
      end
    end
    out_ready_i <= calm || ($urandom_range(99) >= StallPct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned call_pct;
    int unsigned roll;
    logic [63:0] addr;
    logic [63:0] tgt;
    kind_e       kind;
    for (int k = 0; k < HistWords; k++) path_hist[k] = '0;
    for (int k = 0; k < Depth; k++) ret_stack[k] = '0;
    tos_ptr = '0;
    live_cnt = '0;
    call_pct = 50;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++) begin
      for (int rep = 0; rep < int'(dir_rows[r].reps); rep++) begin
        send_branch(dir_rows[r].addr + RowStep * 64'(rep), dir_rows[r].kind,
                    dir_rows[r].target, dir_rows[r].typed, dir_rows[r].want);
      end
    end
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);

    for (int i = 0; i < RandBeats; i++) begin
      calm = (i >= 700 && i < 1000);
      if (i == 1200) begin
        in_valid_i <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      // push-heavy, balanced and pop-heavy stretches
      if (i % 200 == 0) call_pct = 25 * $urandom_range(3, 1);
      addr = {$urandom, $urandom};
      if ($urandom_range(31) == 0) addr[63:8] = '1;
      tgt = {$urandom, $urandom};
      roll = $urandom_range(99);
      if (roll < 8) begin
        kind = KIND_OTHER;
      end else begin
        roll = $urandom_range(99);
        if (roll < call_pct) begin
          kind = $urandom_range(1) ? KIND_INDIRECT_CALL : KIND_DIRECT_CALL;
        end else if (roll < call_pct + (100 - call_pct) * 2 / 3) begin
          kind = KIND_RETURN;
        end else begin
          kind = KIND_OTHER;
          tgt = ret_stack[tos_ptr];
        end
      end
      send_branch(addr, kind, tgt, 1'b0, '0);
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (bad_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
